// ===== src/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// bfra_pkg: shared definitions for the best-fit range allocator
// Field widths, status and operation codes, and the free-table command bundle.
// ----------------------------------------------------------------------------
package bfra_pkg;

  // Fixed field widths
  localparam int SIZE_W   = 21;
  localparam int OFF_W    = 20;
  localparam int LG_W     = 5;
  localparam int CFG_W    = 21;

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Free-table write side commands
  typedef struct packed {
    logic wr;    // write entry, mark valid
    logic clr;   // mark entry empty
    logic init;  // write entry 0, mark only entry 0 valid
  } tbl_cmd_t;

endpackage

// ===== src/bfra_table.sv =====
// ----------------------------------------------------------------------------
// bfra_table: free-range table storage
// Start and end memories with one write and one registered read port, plus
// per-entry valid flags held in flip-flops.
// ----------------------------------------------------------------------------
module bfra_table #(
  parameter int ADDR_BITS  = 20,
  parameter int MAX_RANGES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bfra_pkg::tbl_cmd_t                 cmd,
  input  logic [$clog2(MAX_RANGES)-1:0]      wr_addr,
  input  logic [ADDR_BITS-1:0]               wr_start,
  input  logic [ADDR_BITS:0]                 wr_end,
  input  logic [$clog2(MAX_RANGES)-1:0]      rd_addr,
  output logic [ADDR_BITS-1:0]               rd_start,
  output logic [ADDR_BITS:0]                 rd_end,
  output logic                               rd_vbit
);
  import bfra_pkg::*;

  logic [ADDR_BITS-1:0] start_mem [MAX_RANGES];
  logic [ADDR_BITS:0]   end_mem   [MAX_RANGES];
  logic [MAX_RANGES-1:0] vbits;

  // Write entry contents
  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.init) begin
      start_mem[wr_addr] <= wr_start;
      end_mem[wr_addr]   <= wr_end;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
    rd_vbit  <= vbits[rd_addr];
  end

  // Track occupied entries
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= MAX_RANGES'(1);
    end else if (cmd.init) begin
      vbits <= MAX_RANGES'(1);
    end else if (cmd.wr) begin
      vbits[wr_addr] <= 1'b1;
    end else if (cmd.clr) begin
      vbits[wr_addr] <= 1'b0;
    end
  end

endmodule

// ===== src/bfra_fit.sv =====
// ----------------------------------------------------------------------------
// bfra_fit: two-stage fit evaluator
// Aligns a free range's start, then checks whether the request fits and
// computes the units left behind the granted area.
// ----------------------------------------------------------------------------
module bfra_fit #(
  parameter int ADDR_BITS  = 20,
  parameter int MAX_RANGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   live_in,
  input  logic [$clog2(MAX_RANGES)-1:0]          idx_in,
  input  logic [ADDR_BITS-1:0]                   start_in,
  input  logic [ADDR_BITS:0]                     end_in,
  input  logic [bfra_pkg::LG_W-1:0]              lg,
  input  logic [bfra_pkg::SIZE_W-1:0]            size,
  output logic                                   live,
  output logic                                   fit,
  output logic [ADDR_BITS:0]                     waste,
  output logic [ADDR_BITS:0]                     al,
  output logic [((ADDR_BITS + 1 > bfra_pkg::SIZE_W) ? ADDR_BITS + 1 : bfra_pkg::SIZE_W):0] need,
  output logic [ADDR_BITS-1:0]                   start_o,
  output logic [ADDR_BITS:0]                     end_o,
  output logic [$clog2(MAX_RANGES)-1:0]          idx
);
  import bfra_pkg::*;

  localparam int EW = ADDR_BITS + 1;
  localparam int XW = ((EW > SIZE_W) ? EW : SIZE_W) + 1;
  localparam int IW = $clog2(MAX_RANGES);

  logic [EW-1:0] mask;
  logic          ok_c;
  logic [EW-1:0] al_c;

  logic          a_live;
  logic          a_ok;
  logic [EW-1:0] a_al;
  logic [ADDR_BITS-1:0] a_start;
  logic [EW-1:0] a_end;
  logic [IW-1:0] a_idx;

  logic [XW-1:0] need_c;
  logic [XW:0]   diff_c;

  // Round the start up to the alignment; a large alignment fits only at zero
  always_comb begin
    mask = ~({EW{1'b1}} << lg);
    ok_c = (start_in == '0) || (int'(lg) <= ADDR_BITS);
    al_c = (EW'(start_in) + mask) & ~mask;
  end

  // Stage A: aligned start
  always_ff @(posedge clk) begin
    if (rst) begin
      a_live <= 1'b0;
    end else begin
      a_live <= live_in;
    end
  end

  always_ff @(posedge clk) begin
    a_ok    <= ok_c;
    a_al    <= al_c;
    a_start <= start_in;
    a_end   <= end_in;
    a_idx   <= idx_in;
  end

  // Granted end and leftover; a borrow means no fit
  always_comb begin
    need_c = XW'(a_al) + XW'(size);
    diff_c = {1'b0, XW'(a_end)} - {1'b0, need_c};
  end

  // Stage B: fit result
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else begin
      live <= a_live;
    end
  end

  always_ff @(posedge clk) begin
    fit     <= a_ok && !diff_c[XW];
    waste   <= diff_c[EW-1:0];
    al      <= a_al;
    need    <= need_c;
    start_o <= a_start;
    end_o   <= a_end;
    idx     <= a_idx;
  end

endmodule

// ===== src/best_fit_range_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_range_allocator_unit: best-fit allocator over a free-range table
// Grants aligned ranges with least leftover and returns freed ranges with
// merging of touching neighbors.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on in_valid/in_ready with op, req_size, align_log2 and
//   free_offset; each request yields exactly one result on out_valid/out_ready
//   (status, alloc_offset, granted_size). One request is in flight at a time.
//   A request that needs the table runs a full table scan: one entry is read
//   per cycle through the single read port and fed to the shared fit unit,
//   then up to two table writes follow. A zero-size request or a free
//   beyond the region skips the scan and goes straight to the result.
//   The next request is taken once the result is in the output register;
//   a stalled receiver only holds the block if a second result is ready
//   before the first has been taken.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the pool
//   size, clamped to 1 .. 2^ADDR_BITS, and resets the table to one range.
//   Reset sets the pool size to 2^ADDR_BITS and starts by rebuilding the
//   table; each configuration transfer also leads to a rebuild.
// ----------------------------------------------------------------------------
module best_fit_range_allocator_unit #(
  parameter int ADDR_BITS  = 20,
  parameter int MAX_RANGES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfra_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [bfra_pkg::SIZE_W-1:0]      req_size,
  input  logic [bfra_pkg::LG_W-1:0]        align_log2,
  input  logic [bfra_pkg::OFF_W-1:0]       free_offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bfra_pkg::status_t                status,
  output logic [bfra_pkg::OFF_W-1:0]       alloc_offset,
  output logic [bfra_pkg::SIZE_W-1:0]      granted_size
);
  import bfra_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int EW    = ADDR_BITS + 1;
  localparam int XW    = ((EW > SIZE_W) ? EW : SIZE_W) + 1;
  localparam int IW    = $clog2(MAX_RANGES);
  localparam int STEPS = MAX_RANGES + 3;
  localparam int SW    = $clog2(STEPS + 1);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_UPD1 = 6'b001000,
    S_UPD2 = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t        state;
  logic [EW-1:0] pool_size;

  // Request
  logic              req_op;
  logic [SIZE_W-1:0] req_sz;
  logic [LG_W-1:0]   req_lg;
  logic [XW-1:0]     lo;
  logic [XW-1:0]     hi;
  logic [SW-1:0]     step;

  // Scan pipeline
  logic          p1_live;
  logic [IW-1:0] p1_idx;
  logic [AW-1:0] rd_start;
  logic [EW-1:0] rd_end;
  logic          rd_vbit;
  logic          f_live;
  logic          f_fit;
  logic [EW-1:0] f_waste;
  logic [EW-1:0] f_al;
  logic [XW-1:0] f_need;
  logic [AW-1:0] f_start;
  logic [EW-1:0] f_end;
  logic [IW-1:0] f_idx;

  // Best candidate, merge target, first empty slot
  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [EW-1:0] best_waste;
  logic [EW-1:0] best_al;
  logic [XW-1:0] best_need;
  logic [AW-1:0] best_start;
  logic [EW-1:0] best_end;
  logic          tgt_found;
  logic [IW-1:0] tgt_idx;
  logic          empty_found;
  logic [IW-1:0] empty_idx;

  // Pending table writes
  logic          wa_clr;
  logic [IW-1:0] wa_addr;
  logic [AW-1:0] wa_start;
  logic [EW-1:0] wa_end;
  logic [IW-1:0] wb_addr;
  logic [AW-1:0] wb_start;
  logic [EW-1:0] wb_end;
  logic          two_wr;

  // Result staging
  status_t           res_status;
  logic [OFF_W-1:0]  res_offset;
  logic [SIZE_W-1:0] res_granted;

  // Table port
  tbl_cmd_t      tcmd;
  logic [IW-1:0] t_waddr;
  logic [AW-1:0] t_wstart;
  logic [EW-1:0] t_wend;
  logic [IW-1:0] t_raddr;
  logic          issue;

  // Combinational helpers
  logic          merge_hit;
  logic [XW-1:0] cfg_x;
  logic [XW-1:0] pool_max_x;
  logic [XW-1:0] cfg_clamp;
  logic [XW-1:0] pool_x;
  logic [XW-1:0] al_x;
  logic          has_pad;
  logic          has_tail;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Clamp the written pool size into 1 .. 2^ADDR_BITS
  always_comb begin
    cfg_x      = XW'(cfg_data);
    pool_max_x = XW'({1'b1, {AW{1'b0}}});
    if (cfg_x == '0) begin
      cfg_clamp = XW'(1);
    end else if (cfg_x > pool_max_x) begin
      cfg_clamp = pool_max_x;
    end else begin
      cfg_clamp = cfg_x;
    end
    pool_x   = XW'(pool_size);
    al_x     = XW'(best_al);
    has_pad  = (best_al != EW'(best_start));
    has_tail = (best_waste != '0);
  end

  // Free: entry touches or overlaps the growing range
  assign merge_hit = (req_op == OP_FREE) && p1_live && rd_vbit &&
                     (XW'(rd_start) <= hi) && (XW'(rd_end) >= lo);

  // Scan read address
  assign issue   = (state == S_SCAN) && (step < SW'(MAX_RANGES));
  assign t_raddr = issue ? step[IW-1:0] : '0;

  // Drive the table write side
  always_comb begin
    tcmd     = '0;
    t_waddr  = wa_addr;
    t_wstart = wa_start;
    t_wend   = wa_end;
    unique case (state)
      S_INIT: begin
        tcmd.init = 1'b1;
        t_waddr   = '0;
        t_wstart  = '0;
        t_wend    = pool_size;
      end
      S_SCAN: begin
        if (merge_hit && tgt_found) begin
          tcmd.clr = 1'b1;
          t_waddr  = p1_idx;
        end
      end
      S_UPD1: begin
        tcmd.wr  = !wa_clr;
        tcmd.clr = wa_clr;
      end
      S_UPD2: begin
        tcmd.wr  = 1'b1;
        t_waddr  = wb_addr;
        t_wstart = wb_start;
        t_wend   = wb_end;
      end
      default: begin
      end
    endcase
  end

  bfra_table #(
    .ADDR_BITS  (ADDR_BITS),
    .MAX_RANGES (MAX_RANGES)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tcmd),
    .wr_addr  (t_waddr),
    .wr_start (t_wstart),
    .wr_end   (t_wend),
    .rd_addr  (t_raddr),
    .rd_start (rd_start),
    .rd_end   (rd_end),
    .rd_vbit  (rd_vbit)
  );

  bfra_fit #(
    .ADDR_BITS  (ADDR_BITS),
    .MAX_RANGES (MAX_RANGES)
  ) u_fit (
    .clk      (clk),
    .rst      (rst),
    .live_in  (p1_live && rd_vbit && (req_op == OP_ALLOC)),
    .idx_in   (p1_idx),
    .start_in (rd_start),
    .end_in   (rd_end),
    .lg       (req_lg),
    .size     (req_sz),
    .live     (f_live),
    .fit      (f_fit),
    .waste    (f_waste),
    .al       (f_al),
    .need     (f_need),
    .start_o  (f_start),
    .end_o    (f_end),
    .idx      (f_idx)
  );

  // Tag the entry whose read data arrives next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_live <= 1'b0;
    end else begin
      p1_live <= issue;
    end
    p1_idx <= step[IW-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      pool_size   <= {1'b1, {AW{1'b0}}};
      step        <= '0;
      best_found  <= 1'b0;
      tgt_found   <= 1'b0;
      empty_found <= 1'b0;
      two_wr      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end

        S_IDLE: begin
          if (cfg_valid) begin
            pool_size <= EW'(cfg_clamp);
            state     <= S_INIT;
          end else if (in_valid) begin
            req_op      <= op;
            req_sz      <= req_size;
            req_lg      <= align_log2;
            lo          <= XW'(free_offset);
            hi          <= XW'(free_offset) + XW'(req_size);
            step        <= '0;
            best_found  <= 1'b0;
            tgt_found   <= 1'b0;
            empty_found <= 1'b0;
            two_wr      <= 1'b0;
            res_offset  <= '0;
            res_granted <= '0;
            if (op == OP_ALLOC && req_size == '0) begin
              res_status <= ST_NOFIT;
              state      <= S_RESP;
            end else if (op == OP_FREE &&
                         (req_size == '0 || XW'(free_offset) >= pool_x)) begin
              res_status <= ST_OK;
              state      <= S_RESP;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          step <= step + SW'(1);

          // Clip the released range to the region
          if (step == '0 && hi > pool_x) begin
            hi <= pool_x;
          end

          // Note the lowest empty slot
          if (p1_live && !rd_vbit && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= p1_idx;
          end

          // Free: grow the range; first touching slot becomes the target
          if (merge_hit) begin
            if (XW'(rd_start) < lo) begin
              lo <= XW'(rd_start);
            end
            if (XW'(rd_end) > hi) begin
              hi <= XW'(rd_end);
            end
            if (!tgt_found) begin
              tgt_found <= 1'b1;
              tgt_idx   <= p1_idx;
            end
          end

          // Allocate: keep the fit with least leftover, lowest slot on ties
          if (f_live && f_fit && (!best_found || f_waste < best_waste)) begin
            best_found <= 1'b1;
            best_idx   <= f_idx;
            best_waste <= f_waste;
            best_al    <= f_al;
            best_need  <= f_need;
            best_start <= f_start;
            best_end   <= f_end;
          end

          // Scan done: plan the table update
          if (step == SW'(STEPS)) begin
            if (req_op == OP_ALLOC) begin
              if (!best_found) begin
                res_status <= ST_NOFIT;
                state      <= S_RESP;
              end else if (has_pad && has_tail && !empty_found) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                res_offset  <= al_x[OFF_W-1:0];
                res_granted <= req_sz;
                wa_addr     <= best_idx;
                wa_clr      <= !has_pad && !has_tail;
                two_wr      <= has_pad && has_tail;
                state       <= S_UPD1;
                // Padding keeps the slot; otherwise the tail does (with neither, the slot is cleared)
                if (has_pad) begin
                  wa_start <= best_start;
                  wa_end   <= best_al;
                end else begin
                  wa_start <= best_need[AW-1:0];
                  wa_end   <= best_end;
                end
                // A tail beside the padding takes the lowest empty slot
                if (has_pad && has_tail) begin
                  wb_addr  <= empty_idx;
                  wb_start <= best_need[AW-1:0];
                  wb_end   <= best_end;
                end
              end
            end else begin
              wa_clr   <= 1'b0;
              wa_start <= lo[AW-1:0];
              wa_end   <= hi[EW-1:0];
              if (tgt_found) begin
                wa_addr <= tgt_idx;
                state   <= S_UPD1;
              end else if (empty_found) begin
                wa_addr <= empty_idx;
                state   <= S_UPD1;
              end else begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end
            end
          end
        end

        S_UPD1: begin
          state <= two_wr ? S_UPD2 : S_RESP;
        end

        S_UPD2: begin
          state <= S_RESP;
        end

        S_RESP: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            alloc_offset <= res_offset;
            granted_size <= res_granted;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request keeps the block busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("request transfer not followed by busy");

  // A failed request carries no grant; free requests report none either
  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_size == '0 && alloc_offset == '0)
    else $error("grant reported on failed request");

  // A pool size write rebuilds the table next
  a_cfg_init: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> state == S_INIT)
    else $error("pool size write did not rebuild the table");

  // Entry writes with wr happen only from the update states; the rebuild uses init
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    tcmd.wr |-> state == S_UPD1 || state == S_UPD2)
    else $error("table write outside update");

endmodule
